/* rtl/core/lpsp_pkg.sv */
// lpsp_pkg: shared types and constants for the login packet stream parser
// used by the channel interfaces, the parse core and the top level
package lpsp_pkg;

  localparam int unsigned ID_W = 10;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_VERSION,
    PH_PAYLEN,
    PH_STRLEN,
    PH_STRDATA,
    PH_TAIL,
    PH_EXPECT_END
  } phase_t;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_TRUNCATED  = 3'd1;
  localparam status_t ST_VARINT_BIG = 3'd2;
  localparam status_t ST_WRONG_ID   = 3'd3;
  localparam status_t ST_MISMATCH   = 3'd4;
  localparam status_t ST_TRAILING   = 3'd5;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_STATUS  = 2'd0;
  localparam kind_t KIND_IDENT   = 2'd1;
  localparam kind_t KIND_CLIENT  = 2'd2;
  localparam kind_t KIND_VERSION = 2'd3;

  localparam logic [2:0] VARINT_LAST = 3'd4;

  typedef struct packed {
    logic        have;
    kind_t       kind;
    logic [7:0]  text_byte;
    logic [31:0] version_word;
    logic        finished;
    status_t     status;
  } result_t;

endpackage

/* rtl/core/lpsp_ifs.sv */
// lpsp_ifs: valid/ready channel interfaces for bytes in, results out and config
// depends on lpsp_pkg
interface lpsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;
  modport source (output valid, data_byte, end_of_packet, input ready);
  modport sink (input valid, data_byte, end_of_packet, output ready);
endinterface

interface lpsp_out_if;
  logic                 valid;
  logic                 ready;
  lpsp_pkg::kind_t      kind;
  logic [7:0]           text_byte;
  logic [31:0]          version_word;
  logic                 finished;
  lpsp_pkg::status_t    status;
  modport source (output valid, kind, text_byte, version_word, finished, status,
                  input ready);
  modport sink (input valid, kind, text_byte, version_word, finished, status,
                output ready);
endinterface

interface lpsp_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lpsp_pkg::ID_W-1:0] login_packet_id;
  modport source (output valid, login_packet_id, input ready);
  modport sink (input valid, login_packet_id, output ready);
endinterface

/* rtl/core/login_packet_stream_parser.sv */
// login_packet_stream_parser: top level, input word register, parse core and
// result register; depends on lpsp_pkg, lpsp_ifs and lpsp_core
//
// in_ch carries one packet byte per word with an end-of-packet flag. out_ch
// carries zero or one result per byte: a version word, an identity or client
// string byte, and/or a final status (finished = 1) for the packet.
// cfg_ch writes the expected packet id; it is always ready and is meant to
// be written only while no byte is in flight.
// A byte accepted into the input register is parsed when it advances out of
// it, and any result it gives is registered in the result register for out_ch.
// Throughput: one byte per cycle. The input register and the result register
// let a new byte enter while a result waits; a byte stays in the input
// register only while the result register is full and out_ch.ready is low,
// and then in_ch.ready drops.
// After an error the parser gives no result up to and including the byte with the end flag.
// Reset (rst_n low, synchronous) empties both registers, returns the parser
// to the header phase and sets the packet id to 1.
module login_packet_stream_parser (
  input logic          clk,
  input logic          rst_n,
  lpsp_cfg_if.sink     cfg_ch,
  lpsp_in_if.sink      in_ch,
  lpsp_out_if.source   out_ch
);

  logic [lpsp_pkg::ID_W-1:0] login_id_r;
  logic                      in_valid_r, in_valid_nxt;
  logic [7:0]                in_byte_r;
  logic                      in_eop_r;
  logic                      out_valid_r, out_valid_nxt;
  lpsp_pkg::result_t         out_r;
  lpsp_pkg::result_t         res;
  logic                      advance;
  logic                      in_fire;

  assign cfg_ch.ready = 1'b1;
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;

  lpsp_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .data_byte     (in_byte_r),
    .end_of_packet (in_eop_r),
    .login_id      (login_id_r),
    .res           (res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_fire) in_valid_nxt = 1'b1;
    else if (advance) in_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (advance) out_valid_nxt = res.have;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      login_id_r  <= lpsp_pkg::ID_W'(1);
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) login_id_r <= cfg_ch.login_packet_id;
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_ch.data_byte;
      in_eop_r  <= in_ch.end_of_packet;
    end
    if (advance && res.have) out_r <= res;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_r.kind;
  assign out_ch.text_byte    = out_r.text_byte;
  assign out_ch.version_word = out_r.version_word;
  assign out_ch.finished     = out_r.finished;
  assign out_ch.status       = out_r.status;

  a_status_only_when_finished: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.finished |-> out_ch.status == lpsp_pkg::ST_OK)
    else $error("status set on an unfinished result");

  a_text_only_for_strings: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.kind == lpsp_pkg::KIND_STATUS ||
                     out_ch.kind == lpsp_pkg::KIND_VERSION) |-> out_ch.text_byte == 8'd0)
    else $error("text byte set outside a string result");

  a_version_only_for_version: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind != lpsp_pkg::KIND_VERSION |-> out_ch.version_word == '0)
    else $error("version word set outside a version result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> in_valid_r && out_valid_r && !out_ch.ready)
    else $error("input stalled without a full pipeline");

  a_stalled_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_r))
    else $error("stalled result lost or changed");

endmodule

/* rtl/core/lpsp_core.sv */
// lpsp_core: parse state and one-word step logic of the login packet parser
// depends on lpsp_pkg
module lpsp_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [7:0]                data_byte,
  input  logic                      end_of_packet,
  input  logic [lpsp_pkg::ID_W-1:0] login_id,
  output lpsp_pkg::result_t         res
);

  lpsp_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] vint_val_r, vint_val_nxt;
  logic [2:0]  vint_cnt_r, vint_cnt_nxt;
  logic [31:0] word_r, word_nxt;
  logic [1:0]  word_cnt_r, word_cnt_nxt;
  logic [31:0] pay_left_r, pay_left_nxt;
  logic [31:0] str_left_r, str_left_nxt;
  logic        second_r, second_nxt;
  logic        err_r, err_nxt;
  logic        pay_over_r, pay_over_nxt;

  logic        fin_valid;
  lpsp_pkg::status_t fin_code;
  logic        str_end;
  logic [4:0]  vint_sh;
  logic [31:0] vint_or;
  logic [31:0] word_or;

  always_comb begin
    unique case (vint_cnt_r)
      3'd0:    vint_sh = 5'd0;
      3'd1:    vint_sh = 5'd7;
      3'd2:    vint_sh = 5'd14;
      3'd3:    vint_sh = 5'd21;
      default: vint_sh = 5'd28;
    endcase
    vint_or = vint_val_r | ({25'd0, data_byte[6:0]} << vint_sh);
    word_or = word_r | ({24'd0, data_byte} << {word_cnt_r, 3'b000});
  end

  always_comb begin
    phase_nxt    = phase_r;
    vint_val_nxt = vint_val_r;
    vint_cnt_nxt = vint_cnt_r;
    word_nxt     = word_r;
    word_cnt_nxt = word_cnt_r;
    pay_left_nxt = pay_left_r;
    str_left_nxt = str_left_r;
    second_nxt   = second_r;
    err_nxt      = err_r;
    pay_over_nxt = pay_over_r;
    fin_valid    = 1'b0;
    fin_code     = lpsp_pkg::ST_OK;
    str_end      = 1'b0;
    res          = '0;

    if (err_r) begin
      // swallow words until the end flag
      if (end_of_packet) begin
        phase_nxt    = lpsp_pkg::PH_HEADER;
        vint_val_nxt = '0;
        vint_cnt_nxt = '0;
        word_nxt     = '0;
        word_cnt_nxt = '0;
        pay_left_nxt = '0;
        str_left_nxt = '0;
        second_nxt   = 1'b0;
        err_nxt      = 1'b0;
        pay_over_nxt = 1'b0;
      end
    end else begin
      unique case (phase_r)
        lpsp_pkg::PH_HEADER, lpsp_pkg::PH_PAYLEN: begin
          vint_val_nxt = vint_or;
          if (data_byte[7]) begin
            if (vint_cnt_r >= lpsp_pkg::VARINT_LAST) begin
              fin_valid = 1'b1;
              fin_code  = lpsp_pkg::ST_VARINT_BIG;
            end else begin
              vint_cnt_nxt = vint_cnt_r + 3'd1;
            end
          end else begin
            vint_val_nxt = '0;
            vint_cnt_nxt = '0;
            if (phase_r == lpsp_pkg::PH_HEADER) begin
              if (vint_or[lpsp_pkg::ID_W-1:0] != login_id) begin
                fin_valid = 1'b1;
                fin_code  = lpsp_pkg::ST_WRONG_ID;
              end else begin
                phase_nxt = lpsp_pkg::PH_VERSION;
              end
            end else begin
              pay_left_nxt = vint_or;
              pay_over_nxt = 1'b0;
              second_nxt   = 1'b0;
              phase_nxt    = lpsp_pkg::PH_STRLEN;
            end
          end
        end
        lpsp_pkg::PH_VERSION: begin
          word_nxt     = {word_r[23:0], data_byte};
          word_cnt_nxt = word_cnt_r + 2'd1;
          if (word_cnt_r == 2'd3) begin
            res.have         = 1'b1;
            res.kind         = lpsp_pkg::KIND_VERSION;
            res.version_word = {word_r[23:0], data_byte};
            word_nxt         = '0;
            phase_nxt        = lpsp_pkg::PH_PAYLEN;
          end
        end
        lpsp_pkg::PH_STRLEN: begin
          if (pay_left_r == '0) pay_over_nxt = 1'b1;
          else pay_left_nxt = pay_left_r - 32'd1;
          word_nxt     = word_or;
          word_cnt_nxt = word_cnt_r + 2'd1;
          if (word_cnt_r == 2'd3) begin
            str_left_nxt = word_or;
            word_nxt     = '0;
            if (word_or == '0) str_end = 1'b1;
            else phase_nxt = lpsp_pkg::PH_STRDATA;
          end
        end
        lpsp_pkg::PH_STRDATA: begin
          if (pay_left_r == '0) pay_over_nxt = 1'b1;
          else pay_left_nxt = pay_left_r - 32'd1;
          res.have      = 1'b1;
          res.kind      = second_r ? lpsp_pkg::KIND_CLIENT : lpsp_pkg::KIND_IDENT;
          res.text_byte = data_byte;
          str_left_nxt  = str_left_r - 32'd1;
          if (str_left_r == 32'd1) str_end = 1'b1;
        end
        lpsp_pkg::PH_TAIL: begin
          pay_left_nxt = pay_left_r - 32'd1;
          if (pay_left_r == 32'd1) begin
            fin_valid = 1'b1;
            fin_code  = lpsp_pkg::ST_MISMATCH;
          end
        end
        default: begin
          fin_valid = 1'b1;
          fin_code  = lpsp_pkg::ST_TRAILING;
        end
      endcase

      // end of a string
      if (str_end) begin
        if (!second_r) begin
          second_nxt = 1'b1;
          phase_nxt  = lpsp_pkg::PH_STRLEN;
        end else if (pay_over_nxt) begin
          fin_valid = 1'b1;
          fin_code  = lpsp_pkg::ST_MISMATCH;
        end else if (pay_left_nxt == '0) begin
          if (end_of_packet) begin
            fin_valid = 1'b1;
            fin_code  = lpsp_pkg::ST_OK;
          end else begin
            phase_nxt = lpsp_pkg::PH_EXPECT_END;
          end
        end else begin
          phase_nxt = lpsp_pkg::PH_TAIL;
        end
      end

      if (!fin_valid && end_of_packet) begin
        fin_valid = 1'b1;
        fin_code  = lpsp_pkg::ST_TRUNCATED;
      end

      if (fin_valid) begin
        res.have     = 1'b1;
        res.finished = 1'b1;
        res.status   = fin_code;
        phase_nxt    = lpsp_pkg::PH_HEADER;
        vint_val_nxt = '0;
        vint_cnt_nxt = '0;
        word_nxt     = '0;
        word_cnt_nxt = '0;
        pay_left_nxt = '0;
        str_left_nxt = '0;
        second_nxt   = 1'b0;
        pay_over_nxt = 1'b0;
        err_nxt      = !end_of_packet;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= lpsp_pkg::PH_HEADER;
      vint_val_r <= '0;
      vint_cnt_r <= '0;
      word_r     <= '0;
      word_cnt_r <= '0;
      pay_left_r <= '0;
      str_left_r <= '0;
      second_r   <= 1'b0;
      err_r      <= 1'b0;
      pay_over_r <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      vint_val_r <= vint_val_nxt;
      vint_cnt_r <= vint_cnt_nxt;
      word_r     <= word_nxt;
      word_cnt_r <= word_cnt_nxt;
      pay_left_r <= pay_left_nxt;
      str_left_r <= str_left_nxt;
      second_r   <= second_nxt;
      err_r      <= err_nxt;
      pay_over_r <= pay_over_nxt;
    end
  end

endmodule

/* bench/login_packet_stream_parser_test.sv */
// login_packet_stream_parser_test: drives byte words with random gaps and stalls,
// predicts each result word from its own parse state and checks it field by field
// depends on lpsp_pkg, lpsp_ifs and login_packet_stream_parser
module login_packet_stream_parser_test;

  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_REPORTS   = 10;
  localparam int NO_STATUS     = -1;

  typedef struct packed {
    logic [7:0] data;
    logic       eop;
  } stream_word_t;

  typedef struct packed {
    lpsp_pkg::kind_t   kind;
    logic [7:0]        text_byte;
    logic [31:0]       version_word;
    logic              finished;
    lpsp_pkg::status_t status;
  } result_word_t;

  typedef enum int {
    PK_GOOD, PK_WRONG_ID, PK_VARINT_BIG, PK_CUT, PK_SHORT_PAY,
    PK_LONG_PAY, PK_LONG_PAY_CUT, PK_TRAILING, PK_HUGE_LEN, PK_NOISE
  } packet_shape_t;

  logic clk = 1'b0;
  logic rst_n;

  lpsp_cfg_if cfg_ch ();
  lpsp_in_if  in_ch ();
  lpsp_out_if out_ch ();

  login_packet_stream_parser u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stream_word_t byte_backlog[$];
  result_word_t due_results[$];
  logic [7:0]   frame[$];

  logic       in_gaps_on;
  logic       out_gaps_on;
  int         in_gap;
  int         out_gap;
  int         quiet_cycles;
  int         queued_bytes;
  int         bytes_in;
  int         results_seen;
  int         id_writes;
  int         mismatches;
  int         cfg_req_cnt;
  int         cfg_done_cnt;
  logic [9:0] cur_id;
  logic [9:0] next_id;
  int         status_seen[0:7];

  // parse state of the predictor
  lpsp_pkg::phase_t ph;
  logic [31:0] vint_acc;
  int          vint_cnt;
  logic [31:0] word_acc;
  int          word_cnt;
  logic [31:0] pay_left;
  logic [31:0] str_left;
  logic        second_str;
  logic        err_latched;
  logic        pay_over;
  logic [9:0]  pkt_id;

  function void restart_packet();
    ph = lpsp_pkg::PH_HEADER;
    vint_acc = '0;
    vint_cnt = 0;
    word_acc = '0;
    word_cnt = 0;
    pay_left = '0;
    str_left = '0;
    second_str = 1'b0;
    err_latched = 1'b0;
    pay_over = 1'b0;
  endfunction

  function void take_payload_byte();
    if (pay_left == 0) pay_over = 1'b1;
    else pay_left = pay_left - 1;
  endfunction

  function int string_end(input logic eop);
    if (!second_str) begin
      second_str = 1'b1;
      ph = lpsp_pkg::PH_STRLEN;
      return NO_STATUS;
    end
    if (pay_over) return lpsp_pkg::ST_MISMATCH;
    if (pay_left == 0) begin
      if (eop) return lpsp_pkg::ST_OK;
      ph = lpsp_pkg::PH_EXPECT_END;
      return NO_STATUS;
    end
    ph = lpsp_pkg::PH_TAIL;
    return NO_STATUS;
  endfunction

  function void parse_byte(input logic [7:0] b, input logic eop);
    int           fin;
    logic         have;
    result_word_t r;
    logic [31:0]  v;
    fin = NO_STATUS;
    have = 1'b0;
    r = '0;
    if (err_latched) begin
      if (eop) restart_packet();
      return;
    end
    case (ph)
      lpsp_pkg::PH_HEADER, lpsp_pkg::PH_PAYLEN: begin
        v = {25'd0, b[6:0]};
        vint_acc = vint_acc | (v << (7 * vint_cnt));
        if (b[7]) begin
          if (vint_cnt >= lpsp_pkg::VARINT_LAST) fin = lpsp_pkg::ST_VARINT_BIG;
          else vint_cnt++;
        end else begin
          v = vint_acc;
          vint_acc = '0;
          vint_cnt = 0;
          if (ph == lpsp_pkg::PH_HEADER) begin
            if (v[9:0] != pkt_id) fin = lpsp_pkg::ST_WRONG_ID;
            else ph = lpsp_pkg::PH_VERSION;
          end else begin
            pay_left = v;
            pay_over = 1'b0;
            second_str = 1'b0;
            ph = lpsp_pkg::PH_STRLEN;
          end
        end
      end
      lpsp_pkg::PH_VERSION: begin
        word_acc = {word_acc[23:0], b};
        word_cnt++;
        if (word_cnt >= 4) begin
          have = 1'b1;
          r.kind = lpsp_pkg::KIND_VERSION;
          r.version_word = word_acc;
          word_acc = '0;
          word_cnt = 0;
          ph = lpsp_pkg::PH_PAYLEN;
        end
      end
      lpsp_pkg::PH_STRLEN: begin
        take_payload_byte();
        word_acc = word_acc | ({24'd0, b} << (8 * word_cnt));
        word_cnt++;
        if (word_cnt >= 4) begin
          str_left = word_acc;
          word_acc = '0;
          word_cnt = 0;
          if (str_left == 0) fin = string_end(eop);
          else ph = lpsp_pkg::PH_STRDATA;
        end
      end
      lpsp_pkg::PH_STRDATA: begin
        take_payload_byte();
        have = 1'b1;
        r.kind = second_str ? lpsp_pkg::KIND_CLIENT : lpsp_pkg::KIND_IDENT;
        r.text_byte = b;
        str_left = str_left - 1;
        if (str_left == 0) fin = string_end(eop);
      end
      lpsp_pkg::PH_TAIL: begin
        pay_left = pay_left - 1;
        if (pay_left == 0) fin = lpsp_pkg::ST_MISMATCH;
      end
      default: fin = lpsp_pkg::ST_TRAILING;
    endcase
    if (fin == NO_STATUS && eop) fin = lpsp_pkg::ST_TRUNCATED;
    if (fin != NO_STATUS) begin
      have = 1'b1;
      r.finished = 1'b1;
      r.status = fin[2:0];
      status_seen[fin]++;
      restart_packet();
      err_latched = !eop;
    end
    if (have) due_results = {due_results, r};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // byte driver
  always @(posedge clk) begin : drive_bytes
    stream_word_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data_byte <= '0;
      in_ch.end_of_packet <= 1'b0;
      in_gap <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_gap != 0) begin
        in_ch.valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (byte_backlog.size() != 0) begin
        nxt = byte_backlog.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= nxt.data;
        in_ch.end_of_packet <= nxt.eop;
        in_gap <= in_gaps_on ? pick_gap() : 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // id register writes
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_ch.valid <= 1'b0;
      cfg_done_cnt <= 0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      cfg_ch.valid <= 1'b0;
      cfg_done_cnt <= cfg_done_cnt + 1;
    end else if (cfg_req_cnt != cfg_done_cnt && !cfg_ch.valid) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.login_packet_id <= next_id;
    end
  end

  task automatic flag_result(input string what, input result_word_t want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%s result %0d: want kind %0d text %02h ver %08h fin %0b st %0d, ",
               what, results_seen, want.kind, want.text_byte, want.version_word,
               want.finished, want.status,
               "got kind %0d text %02h ver %08h fin %0b st %0d",
               out_ch.kind, out_ch.text_byte, out_ch.version_word,
               out_ch.finished, out_ch.status);
  endtask

  // monitor: result check, then prediction of the byte taken at this edge
  always @(posedge clk) begin : watch_ports
    result_word_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
      pkt_id = 10'd1;
      restart_packet();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        pkt_id = cfg_ch.login_packet_id;
        id_writes++;
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          flag_result("unexpected", '0);
        end else begin
          want = due_results.pop_front();
          if (out_ch.kind !== want.kind || out_ch.text_byte !== want.text_byte ||
              out_ch.version_word !== want.version_word ||
              out_ch.finished !== want.finished || out_ch.status !== want.status)
            flag_result("mismatch", want);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        bytes_in++;
        parse_byte(in_ch.data_byte, in_ch.end_of_packet);
      end
      if (out_gap != 0) begin
        out_ch.ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_ch.ready <= 1'b1;
        if (out_gaps_on && $urandom_range(0, 3) == 0) out_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, due_results.size());
      $display("login_packet_stream_parser_test: errors");
      $finish;
    end
  end

  function automatic void put(input logic [7:0] b, input logic eop);
    stream_word_t w;
    w.data = b;
    w.eop = eop;
    byte_backlog = {byte_backlog, w};
    queued_bytes++;
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    frame = {frame, b};
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_varint(input logic [31:0] value);
    int          n;
    logic [31:0] chunk;
    logic [7:0]  b;
    n = 1;
    while (n < 5 && (value >> (7 * n)) != 0) n++;
    n = n + $urandom_range(0, 5 - n);
    for (int i = 0; i < n; i++) begin
      chunk = (value >> (7 * i)) & 32'h7f;
      b = chunk[7:0];
      if (i < n - 1) b[7] = 1'b1;
      else if (i == 4) b[6:4] = 3'($urandom_range(0, 7));
      add_byte(b);
    end
  endfunction

  function automatic void add_overflow();
    repeat ($urandom_range(5, 7)) add_byte(8'h80 | 8'($urandom_range(0, 127)));
  endfunction

  function automatic void add_be32(input logic [31:0] w);
    add_byte(w[31:24]);
    add_byte(w[23:16]);
    add_byte(w[15:8]);
    add_byte(w[7:0]);
  endfunction

  function automatic void add_le32(input logic [31:0] w);
    add_byte(w[7:0]);
    add_byte(w[15:8]);
    add_byte(w[23:16]);
    add_byte(w[31:24]);
  endfunction

  function automatic int unsigned pick_text_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 5);
    if (r < 97) return $urandom_range(6, 20);
    return $urandom_range(21, 60);
  endfunction

  function automatic logic [31:0] pick_version();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    while (byte_backlog.size() != 0 || in_ch.valid || due_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic build_packet(input int pause_at);
    packet_shape_t shape;
    int unsigned   ident_len;
    int unsigned   client_len;
    int unsigned   extra;
    int            cut;
    logic [31:0]   hdr;
    logic [31:0]   paylen;
    logic [31:0]   ident_word;
    shape = PK_GOOD;
    if ($urandom_range(0, 99) >= 55)
      shape = packet_shape_t'($urandom_range(int'(PK_WRONG_ID), int'(PK_NOISE)));
    ident_len = pick_text_len();
    client_len = pick_text_len();
    paylen = 8 + ident_len + client_len;
    ident_word = ident_len;
    extra = $urandom_range(1, 6);
    hdr = {22'd0, cur_id};
    if ($urandom_range(0, 1)) hdr = hdr | ($urandom & 32'hffff_fc00);
    if (shape == PK_WRONG_ID) hdr = hdr ^ $urandom_range(1, 1023);
    case (shape)
      PK_SHORT_PAY: paylen = paylen - $urandom_range(1, 8);
      PK_LONG_PAY, PK_LONG_PAY_CUT: paylen = paylen + extra;
      PK_HUGE_LEN: begin
        if ($urandom_range(0, 1)) paylen = $urandom | 32'h1000_0000;
        else ident_word = $urandom | 32'h100;
      end
      default: ;
    endcase
    frame.delete();
    if (shape == PK_NOISE) begin
      repeat ($urandom_range(1, 12)) add_byte(rand_byte());
    end else begin
      if (shape == PK_VARINT_BIG && $urandom_range(0, 1)) add_overflow();
      else add_varint(hdr);
      add_be32(pick_version());
      if (shape == PK_VARINT_BIG) add_overflow();
      else add_varint(paylen);
      add_le32(ident_word);
      repeat (ident_len) add_byte(rand_byte());
      add_le32(client_len);
      repeat (client_len) add_byte(rand_byte());
      case (shape)
        PK_LONG_PAY: begin
          repeat (extra) add_byte(rand_byte());
          if ($urandom_range(0, 3) == 0) repeat (2) add_byte(rand_byte());
        end
        PK_LONG_PAY_CUT: repeat (extra - 1) add_byte(rand_byte());
        PK_TRAILING: repeat ($urandom_range(1, 3)) add_byte(rand_byte());
        PK_HUGE_LEN: repeat ($urandom_range(0, 3)) add_byte(rand_byte());
        PK_CUT: begin
          cut = $urandom_range(1, frame.size() - 1);
          while (frame.size() > cut) frame.delete(frame.size() - 1);
        end
        default: ;
      endcase
    end
    foreach (frame[i]) begin
      if (i == pause_at) drain();
      put(frame[i], i == frame.size() - 1);
    end
  endtask

  task automatic write_id(input logic [9:0] value);
    drain();
    cur_id = value;
    next_id = value;
    cfg_req_cnt++;
    while (cfg_done_cnt != cfg_req_cnt) @(negedge clk);
  endtask

  task automatic random_phase(input int count, input int pause_at);
    int target;
    target = queued_bytes + count;
    build_packet(pause_at);
    while (queued_bytes < target) build_packet(-1);
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.end_of_packet = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.login_packet_id = '0;
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
    cfg_req_cnt = 0;
    cur_id = 10'd1;
    next_id = 10'd1;
    queued_bytes = 0;
    bytes_in = 0;
    results_seen = 0;
    id_writes = 0;
    mismatches = 0;
    quiet_cycles = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // five-byte varint overflow, then a swallowed byte up to the end flag
    repeat (5) put(8'h80, 1'b0);
    put(8'hff, 1'b1);
    // wrong id, then end flag inside a varint
    put(8'h02, 1'b1);
    put(8'h81, 1'b1);
    // complete packet: one identity byte, empty client string
    put(8'h01, 1'b0);
    put(8'h80, 1'b0);
    put(8'h00, 1'b0);
    put(8'h00, 1'b0);
    put(8'h01, 1'b0);
    put(8'h09, 1'b0);
    put(8'h01, 1'b0);
    repeat (3) put(8'h00, 1'b0);
    put(8'hff, 1'b0);
    repeat (3) put(8'h00, 1'b0);
    put(8'h00, 1'b1);

    write_id(10'd0);
    random_phase(270, -1);
    write_id(10'd1023);
    random_phase(270, -1);
    in_gaps_on = 1'b0;
    out_gaps_on = 1'b0;
    write_id(10'($urandom_range(0, 1023)));
    random_phase(240, -1);
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
    write_id(10'd1);
    random_phase(270, 9);
    drain();

    $display("%0d bytes parsed, %0d result words checked, %0d id writes",
             bytes_in, results_seen, id_writes);
    $display("packets closed: %0d ok, %0d truncated, %0d varint overflow, ",
             status_seen[lpsp_pkg::ST_OK], status_seen[lpsp_pkg::ST_TRUNCATED],
             status_seen[lpsp_pkg::ST_VARINT_BIG],
             "%0d wrong id, %0d mismatch, %0d trailing",
             status_seen[lpsp_pkg::ST_WRONG_ID], status_seen[lpsp_pkg::ST_MISMATCH],
             status_seen[lpsp_pkg::ST_TRAILING]);
    if (mismatches == 0 && due_results.size() == 0)
      $display("login_packet_stream_parser_test: clean");
    else
      $display("login_packet_stream_parser_test: errors");
    $finish;
  end

endmodule
